// ===== rtl/tcw_pkg.sv =====
package tcw_pkg;

   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELLS      = COLUMNS * ROWS;
   localparam int COPY_CELLS = COLUMNS * (ROWS - 1);

   localparam int ADDR_W    = $clog2(CELLS);
   localparam int CUR_COL_W = $clog2(COLUMNS);
   localparam int CUR_ROW_W = $clog2(ROWS);

   localparam int OP_W     = 2;
   localparam int CHAR_W   = 8;
   localparam int COL_IN_W = 7;
   localparam int ROW_IN_W = 5;
   localparam int LOC_W    = 11;
   localparam int CELL_W   = 16;
   localparam int COLOUR_W = 8;

   localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
   localparam logic [OP_W-1:0] OP_MOVE  = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
   localparam logic [OP_W-1:0] OP_READ  = 2'd3;

   localparam logic [CHAR_W-1:0]   NEWLINE_BYTE = 8'd10;
   localparam logic [COLOUR_W-1:0] COLOUR_RESET = 8'd15;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_INIT   = 5'b00010,
      ST_FILL   = 5'b00100,
      ST_SCROLL = 5'b01000,
      ST_RESP   = 5'b10000
   } state_type;

   typedef struct packed {
      logic              load;
      logic [LOC_W-1:0]  cursor_location;
      logic [CELL_W-1:0] cell_word;
   } result_type;

endpackage

// ===== rtl/text_console_writer.sv =====
// Text console writer: a ROWS x COLUMNS store of 16-bit cells (colour in the high byte,
// character in the low byte) with a cursor, held in one single-port-write RAM with a
// registered read, and driven by one address counter under a small sequencer. One item is
// taken at a time and each gives one transfer on rsp_. A newline or line wrap on the bottom
// row scrolls: the counter copies COLUMNS*(ROWS-1) cells one per cycle and then zero-fills
// the last row. A clear walks every cell. After reset a clearing pass runs before the first
// item is taken; csr_ writes are taken at any time and change the colour of later items.
module text_console_writer
   import tcw_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [OP_W-1:0]     req_op,
   input  logic [CHAR_W-1:0]   req_character,
   input  logic [COL_IN_W-1:0] req_column,
   input  logic [ROW_IN_W-1:0] req_row,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [LOC_W-1:0]    rsp_cursor_location,
   output logic [CELL_W-1:0]   rsp_cell_word,
   input  logic                csr_write_enable,
   input  logic [COLOUR_W-1:0] csr_write_data
);

   logic [COLOUR_W-1:0] colour_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [LOC_W-1:0]    rsp_loc_ff;
   logic [CELL_W-1:0]   rsp_cell_ff;
   logic                out_free;
   result_type          result;

   logic                ram_we;
   logic [ADDR_W-1:0]   ram_waddr;
   logic [CELL_W-1:0]   ram_wdata;
   logic                ram_re;
   logic [ADDR_W-1:0]   ram_raddr;
   logic [CELL_W-1:0]   ram_rdata;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   tcw_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op        (req_op),
      .req_character (req_character),
      .req_column    (req_column),
      .req_row       (req_row),
      .text_colour   (colour_ff),
      .out_free      (out_free),
      .result        (result),
      .ram_we        (ram_we),
      .ram_waddr     (ram_waddr),
      .ram_wdata     (ram_wdata),
      .ram_re        (ram_re),
      .ram_raddr     (ram_raddr),
      .ram_rdata     (ram_rdata)
   );

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_ram (
      .clock         (clock),
      .write_enable  (ram_we),
      .write_address (ram_waddr),
      .write_data    (ram_wdata),
      .read_enable   (ram_re),
      .read_address  (ram_raddr),
      .read_data     (ram_rdata)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (result.load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         colour_ff    <= COLOUR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            colour_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (result.load) begin
         rsp_loc_ff  <= result.cursor_location;
         rsp_cell_ff <= result.cell_word;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cursor_location = rsp_loc_ff;
   assign rsp_cell_word       = rsp_cell_ff;

endmodule

// ===== rtl/tcw_ram.sv =====
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_address,
   input  logic [WIDTH-1:0]         write_data,
   input  logic                     read_enable,
   input  logic [$clog2(DEPTH)-1:0] read_address,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem_ff[read_address];
      end
   end

   assign read_data = read_data_ff;

endmodule

// ===== rtl/tcw_ctrl.sv =====
module tcw_ctrl
   import tcw_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [OP_W-1:0]     req_op,
   input  logic [CHAR_W-1:0]   req_character,
   input  logic [COL_IN_W-1:0] req_column,
   input  logic [ROW_IN_W-1:0] req_row,
   input  logic [COLOUR_W-1:0] text_colour,
   input  logic                out_free,
   output result_type          result,
   output logic                ram_we,
   output logic [ADDR_W-1:0]   ram_waddr,
   output logic [CELL_W-1:0]   ram_wdata,
   output logic                ram_re,
   output logic [ADDR_W-1:0]   ram_raddr,
   input  logic [CELL_W-1:0]   ram_rdata
);

   state_type              state_ff, state_in;
   logic [ADDR_W-1:0]      ctr_ff, ctr_in;
   logic [CELL_W-1:0]      fill_data_ff, fill_data_in;
   logic [CUR_COL_W-1:0]   cur_col_ff, cur_col_in;
   logic [CUR_ROW_W-1:0]   cur_row_ff, cur_row_in;
   logic                   cp_vld_ff, cp_vld_in;
   logic [ADDR_W-1:0]      cp_addr_ff, cp_addr_in;
   logic                   rd_sel_ff, rd_sel_in;

   logic                   accept;
   logic                   col_ok, row_ok;
   logic [ADDR_W-1:0]      cur_addr;
   logic [ADDR_W-1:0]      req_addr;
   logic                   at_bottom;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);

   assign col_ok = ({1'b0, req_column} < (COL_IN_W + 1)'(COLUMNS));
   assign row_ok = ({1'b0, req_row} < (ROW_IN_W + 1)'(ROWS));

   assign cur_addr  = ADDR_W'(cur_row_ff) * ADDR_W'(COLUMNS) + ADDR_W'(cur_col_ff);
   assign req_addr  = ADDR_W'(req_row) * ADDR_W'(COLUMNS) + ADDR_W'(req_column);
   assign at_bottom = (cur_row_ff == CUR_ROW_W'(ROWS - 1));

   always_comb begin
      state_in     = state_ff;
      ctr_in       = ctr_ff;
      fill_data_in = fill_data_ff;
      cur_col_in   = cur_col_ff;
      cur_row_in   = cur_row_ff;
      cp_vld_in    = 1'b0;
      cp_addr_in   = cp_addr_ff;
      rd_sel_in    = rd_sel_ff;
      ram_we       = 1'b0;
      ram_waddr    = cur_addr;
      ram_wdata    = {text_colour, req_character};
      ram_re       = 1'b0;
      ram_raddr    = req_addr;
      result.load            = 1'b0;
      result.cursor_location = LOC_W'(cur_addr);
      result.cell_word       = rd_sel_ff ? ram_rdata : '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rd_sel_in = 1'b0;
               state_in  = ST_RESP;
               case (req_op)
                  OP_PUT: begin
                     if (req_character != NEWLINE_BYTE) begin
                        ram_we = 1'b1;
                     end
                     if ((req_character == NEWLINE_BYTE) ||
                         (cur_col_ff == CUR_COL_W'(COLUMNS - 1))) begin
                        cur_col_in = '0;
                        if (at_bottom) begin
                           state_in = ST_SCROLL;
                           ctr_in   = '0;
                        end else begin
                           cur_row_in = cur_row_ff + 1'b1;
                        end
                     end else begin
                        cur_col_in = cur_col_ff + 1'b1;
                     end
                  end
                  OP_MOVE: begin
                     cur_col_in = col_ok ? CUR_COL_W'(req_column) : CUR_COL_W'(COLUMNS - 1);
                     cur_row_in = row_ok ? CUR_ROW_W'(req_row) : CUR_ROW_W'(ROWS - 1);
                  end
                  OP_CLEAR: begin
                     cur_col_in   = '0;
                     cur_row_in   = '0;
                     ctr_in       = '0;
                     fill_data_in = {text_colour, {CHAR_W{1'b0}}};
                     state_in     = ST_FILL;
                  end
                  OP_READ: begin
                     ram_re    = col_ok && row_ok;
                     rd_sel_in = col_ok && row_ok;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end
         ST_SCROLL: begin
            ram_re     = 1'b1;
            ram_raddr  = ctr_ff + ADDR_W'(COLUMNS);
            ram_we     = cp_vld_ff;
            ram_waddr  = cp_addr_ff;
            ram_wdata  = ram_rdata;
            cp_vld_in  = 1'b1;
            cp_addr_in = ctr_ff;
            ctr_in     = ctr_ff + 1'b1;
            if (ctr_ff == ADDR_W'(COPY_CELLS - 1)) begin
               state_in     = ST_FILL;
               fill_data_in = '0;
            end
         end
         ST_INIT, ST_FILL: begin
            ram_we = 1'b1;
            if (cp_vld_ff) begin
               ram_waddr = cp_addr_ff;
               ram_wdata = ram_rdata;
            end else begin
               ram_waddr = ctr_ff;
               ram_wdata = fill_data_ff;
               ctr_in    = ctr_ff + 1'b1;
               if (ctr_ff == ADDR_W'(CELLS - 1)) begin
                  state_in = (state_ff == ST_INIT) ? ST_IDLE : ST_RESP;
               end
            end
         end
         ST_RESP: begin
            result.load = out_free;
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         ctr_ff       <= '0;
         fill_data_ff <= '0;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         cp_vld_ff    <= 1'b0;
         rd_sel_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ctr_ff       <= ctr_in;
         fill_data_ff <= fill_data_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         cp_vld_ff    <= cp_vld_in;
         rd_sel_ff    <= rd_sel_in;
      end
   end

   always_ff @(posedge clock) begin
      cp_addr_ff <= cp_addr_in;
   end

endmodule

// ===== tb/text_console_checker.sv =====
`timescale 1ns / 100ps
module text_console_checker
   import tcw_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [OP_W-1:0]     req_op,
   input  logic [CHAR_W-1:0]   req_character,
   input  logic [COL_IN_W-1:0] req_column,
   input  logic [ROW_IN_W-1:0] req_row,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [LOC_W-1:0]    rsp_cursor_location,
   input  logic [CELL_W-1:0]   rsp_cell_word,
   input  logic                csr_write_enable,
   input  logic [COLOUR_W-1:0] csr_write_data,
   output int                  failures,
   output int                  outstanding
);

   typedef struct packed {
      logic [LOC_W-1:0]  location;
      logic [CELL_W-1:0] cell_value;
   } console_reply_type;

   logic [CELL_W-1:0]   screen [CELLS];
   int unsigned         cur_col;
   int unsigned         cur_row;
   logic [COLOUR_W-1:0] colour;
   console_reply_type   replies_due [$];

   function automatic void feed_line();
      if (cur_row >= ROWS - 1) begin
         for (int i = 0; i < COPY_CELLS; i++)
            screen[i] = screen[i + COLUMNS];
         for (int i = COPY_CELLS; i < CELLS; i++)
            screen[i] = '0;
         cur_row = ROWS - 1;
      end else begin
         cur_row++;
      end
      cur_col = 0;
   endfunction

   function automatic console_reply_type console_step(logic [OP_W-1:0] op,
                                                      logic [CHAR_W-1:0] ch,
                                                      logic [COL_IN_W-1:0] col,
                                                      logic [ROW_IN_W-1:0] row);
      console_reply_type reply;
      reply.cell_value = '0;
      case (op)
         OP_PUT: begin
            if (ch == NEWLINE_BYTE) begin
               feed_line();
            end else begin
               screen[cur_row * COLUMNS + cur_col] = {colour, ch};
               cur_col++;
               if (cur_col >= COLUMNS)
                  feed_line();
            end
         end
         OP_MOVE: begin
            cur_col = (col < COLUMNS) ? col : COLUMNS - 1;
            cur_row = (row < ROWS) ? row : ROWS - 1;
         end
         OP_CLEAR: begin
            for (int i = 0; i < CELLS; i++)
               screen[i] = {colour, 8'h00};
            cur_col = 0;
            cur_row = 0;
         end
         OP_READ: begin
            if (col < COLUMNS && row < ROWS)
               reply.cell_value = screen[row * COLUMNS + col];
         end
         default: begin
            reply.cell_value = '0;
         end
      endcase
      reply.location = LOC_W'(cur_row * COLUMNS + cur_col);
      return reply;
   endfunction

   always @(posedge clock) begin
      console_reply_type due;
      if (reset) begin
         for (int i = 0; i < CELLS; i++)
            screen[i] = '0;
         cur_col = 0;
         cur_row = 0;
         colour = COLOUR_RESET;
         replies_due.delete();
         failures = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (replies_due.size() == 0) begin
               $error("rsp_ transfer with nothing expected: cursor_location %0d, cell_word %h",
                      rsp_cursor_location, rsp_cell_word);
               failures++;
            end else begin
               due = replies_due.pop_front();
               if (rsp_cursor_location !== due.location) begin
                  $error("cursor_location: expected %0d, got %0d",
                         due.location, rsp_cursor_location);
                  failures++;
               end
               if (rsp_cell_word !== due.cell_value) begin
                  $error("cell_word: expected %h, got %h", due.cell_value, rsp_cell_word);
                  failures++;
               end
            end
         end
         if (req_valid && !req_stall)
            replies_due.push_back(console_step(req_op, req_character, req_column, req_row));
         if (csr_write_enable)
            colour = csr_write_data;
      end
      outstanding = replies_due.size();
   end

endmodule

// ===== tb/tb_text_console_writer.sv =====
`timescale 1ns / 100ps
module tb_text_console_writer;
   import tcw_pkg::*;

   localparam int CYCLE_LIMIT   = 4_000_000;
   localparam int PHASE_ITEMS   = 90;
   localparam int RANDOM_PHASES = 6;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [OP_W-1:0]     req_op = OP_PUT;
   logic [CHAR_W-1:0]   req_character = '0;
   logic [COL_IN_W-1:0] req_column = '0;
   logic [ROW_IN_W-1:0] req_row = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [LOC_W-1:0]    rsp_cursor_location;
   logic [CELL_W-1:0]   rsp_cell_word;
   logic                csr_write_enable = 1'b0;
   logic [COLOUR_W-1:0] csr_write_data = '0;

   int          failures;
   int          outstanding;
   int unsigned cycle_count = 0;
   int          op_count [4] = '{0, 0, 0, 0};
   int          items_sent = 0;
   int          colour_settings = 1;
   bit          quiet = 1'b0;
   int unsigned rsp_wait = 0;

   text_console_writer dut (.*);
   text_console_checker checker_inst (.*);

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // draw a fresh stall length after every result transfer
   always @(posedge clock)
      if (rsp_valid && !rsp_stall)
         rsp_wait = quiet ? 0 : $urandom_range(0, 15);

   always @(negedge clock) begin
      if (rsp_wait > 0) begin
         rsp_stall <= 1'b1;
         rsp_wait--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_request(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch,
                               logic [COL_IN_W-1:0] col, logic [ROW_IN_W-1:0] row);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 15);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_op        <= op;
      req_character <= ch;
      req_column    <= col;
      req_row       <= row;
      do @(posedge clock); while (req_stall);
      op_count[op]++;
      items_sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (outstanding == 0);
      repeat (8) @(negedge clock);
   endtask

   task automatic recolour(logic [COLOUR_W-1:0] shade);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= shade;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      colour_settings++;
   endtask

   function automatic logic [CHAR_W-1:0] random_character();
      return ($urandom_range(0, 9) == 0) ? NEWLINE_BYTE : CHAR_W'($urandom_range(0, 255));
   endfunction

   task automatic write_text_line();
      int col;
      int row;
      int len;
      int reads;
      if ($urandom_range(0, 4) == 0) begin
         col = $urandom_range(0, 127);
         row = $urandom_range(0, 31);
      end else begin
         col = $urandom_range(0, COLUMNS - 1);
         row = $urandom_range(0, ROWS - 1);
      end
      send_request(OP_MOVE, CHAR_W'($urandom), COL_IN_W'(col), ROW_IN_W'(row));
      len = $urandom_range(1, 20);
      repeat (len)
         send_request(OP_PUT, random_character(), COL_IN_W'($urandom), ROW_IN_W'($urandom));
      reads = $urandom_range(1, 4);
      for (int i = 0; i < reads; i++)
         send_request(OP_READ, CHAR_W'($urandom), COL_IN_W'(col + i), ROW_IN_W'(row));
   endtask

   initial begin
      int                  first_item;
      int                  pick;
      logic [OP_W-1:0]     op;
      logic [COLOUR_W-1:0] shade;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_request(OP_PUT, 8'h48, '0, '0);
      send_request(OP_PUT, 8'h00, '0, '0);
      send_request(OP_PUT, 8'hFF, '0, '0);
      send_request(OP_PUT, NEWLINE_BYTE, '0, '0);
      send_request(OP_READ, '0, 7'd0, 5'd0);
      send_request(OP_READ, '0, 7'd1, 5'd0);
      send_request(OP_READ, '0, 7'd2, 5'd0);
      send_request(OP_READ, '0, 7'd127, 5'd31);
      send_request(OP_READ, '0, 7'd80, 5'd0);
      send_request(OP_READ, '0, 7'd0, 5'd25);
      send_request(OP_MOVE, '0, 7'd127, 5'd31);
      send_request(OP_PUT, 8'h55, '0, '0);
      send_request(OP_READ, '0, 7'd79, 5'd23);
      send_request(OP_MOVE, '0, 7'd78, 5'd24);
      send_request(OP_PUT, NEWLINE_BYTE, '0, '0);
      send_request(OP_READ, '0, 7'd79, 5'd22);
      send_request(OP_MOVE, '0, 7'd0, 5'd0);
      recolour(8'h00);
      send_request(OP_PUT, 8'h07, '0, '0);
      send_request(OP_READ, '0, 7'd0, 5'd0);
      send_request(OP_CLEAR, '0, '0, '0);
      send_request(OP_READ, '0, 7'd40, 5'd12);
      recolour(8'hFF);
      send_request(OP_CLEAR, '0, '0, '0);
      send_request(OP_READ, '0, 7'd79, 5'd24);
      send_request(OP_PUT, 8'h0D, '0, '0);
      send_request(OP_READ, '0, 7'd0, 5'd0);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         shade = (p == 0) ? 8'hFF : (p == 1) ? 8'h00 : COLOUR_W'($urandom_range(0, 255));
         recolour(shade);
         quiet = ($urandom_range(0, 3) == 0);
         first_item = items_sent;
         while (items_sent - first_item < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               write_text_line();
            end else if (pick < 97) begin
               op = OP_W'($urandom_range(0, 3));
               if (op == OP_CLEAR)
                  op = OP_READ;
               send_request(op, CHAR_W'($urandom), COL_IN_W'($urandom), ROW_IN_W'($urandom));
            end else begin
               send_request(OP_CLEAR, CHAR_W'($urandom), COL_IN_W'($urandom),
                            ROW_IN_W'($urandom));
            end
         end
      end
      quiet = 1'b0;

      drain();
      repeat (20) @(posedge clock);
      $display("Run covered %0d puts, %0d moves, %0d clears and %0d reads under %0d colours",
               op_count[OP_PUT], op_count[OP_MOVE], op_count[OP_CLEAR], op_count[OP_READ],
               colour_settings);
      $display("Scrolls, line wraps, clamped moves and out-of-range reads took %0d cycles",
               cycle_count);
      if (failures == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
